@@ rtl/sfda_pkg.sv @@
// shared types, constants and helper functions of the stereo fractional delay aligner
`default_nettype none

package sfda_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int DELAY_DEPTH = 2048;
   localparam int ADDR_W      = $clog2(DELAY_DEPTH);
   localparam int FILL_W      = ADDR_W + 1;
   localparam int NUM_TAPS    = 5;
   localparam int TAP_W       = $clog2(NUM_TAPS);
   localparam int FRAC_W      = 16;
   localparam int WHOLE_W     = 11;
   localparam logic [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(DELAY_DEPTH - NUM_TAPS);

   localparam int D_W     = FRAC_W + TAP_W;
   localparam int P_W     = 21;
   localparam int S_W     = 23;
   localparam int W_W     = 19;
   localparam int MUL_W   = 26;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 48;
   localparam int HALF_Q16 = 32768;

   localparam int DIV3_K       = 26;
   localparam int DIV3_OFS_LOG = 22;
   localparam logic signed [MUL_W-1:0] DIV3_R   = MUL_W'((2 ** DIV3_K + 2) / 3);
   localparam logic signed [MUL_W-1:0] DIV3_OFS = MUL_W'(3 * (2 ** DIV3_OFS_LOG));

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      CSR_RIGHT_SEL   = 2'd0,
      CSR_WHOLE       = 2'd1,
      CSR_FRACTION    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DEN_4,
      DEN_6,
      DEN_24
   } den_type;

   typedef enum logic [3:0] {
      ST_W_AB,
      ST_W_CE,
      ST_W_Q,
      ST_W_PQ,
      ST_W_S,
      ST_W_DIV,
      ST_W_FIN,
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               clear;
      logic               right_sel;
      logic [WHOLE_W-1:0] whole;
      logic [FRAC_W-1:0]  fraction;
   } cfg_type;

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   waddr;
      logic [SAMPLE_W-1:0] wdata;
      logic [ADDR_W-1:0]   raddr;
   } line_req_type;

   // j-th interpolation node other than k, ascending
   function automatic logic [TAP_W-1:0] tap_node(input logic [TAP_W-1:0] k,
                                                 input logic [1:0] j);
      logic [TAP_W-1:0] jj;
      jj = TAP_W'(j);
      return (jj < k) ? jj : jj + TAP_W'(1);
   endfunction

   function automatic den_type tap_den(input logic [TAP_W-1:0] k);
      den_type d;
      unique case (k)
         3'd0, 3'd4: d = DEN_24;
         3'd1, 3'd3: d = DEN_6;
         default:    d = DEN_4;
      endcase
      return d;
   endfunction

   function automatic logic tap_neg(input logic [TAP_W-1:0] k);
      return (k == TAP_W'(1)) || (k == TAP_W'(3));
   endfunction

   function automatic logic signed [PROD_W-1:0] tap_half_den(input logic [TAP_W-1:0] k);
      logic signed [PROD_W-1:0] h;
      unique case (tap_den(k))
         DEN_4:   h = PROD_W'(4 * HALF_Q16);
         DEN_6:   h = PROD_W'(6 * HALF_Q16);
         DEN_24:  h = PROD_W'(24 * HALF_Q16);
         default: h = PROD_W'(4 * HALF_Q16);
      endcase
      return h;
   endfunction

   // fraction minus node position, Q16
   function automatic logic signed [D_W-1:0] node_dist(input logic [FRAC_W-1:0] frac,
                                                       input logic [TAP_W-1:0] m);
      return $signed(D_W'(frac)) - $signed({m, {FRAC_W{1'b0}}});
   endfunction

   function automatic logic signed [P_W-1:0] round_q16(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = v + PROD_W'(HALF_Q16);
      return P_W'(t >>> FRAC_W);
   endfunction

endpackage

`default_nettype wire

@@ rtl/sfda_mul.sv @@
// shared registered signed multiplier
`default_nettype none

module sfda_mul
   import sfda_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  mul_a,
   input  wire logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]      mul_prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

@@ rtl/sfda_line.sv @@
// circular delay line memory, one write and one registered read per cycle
`default_nettype none

module sfda_line
   import sfda_pkg::*;
(
   input  wire logic                      clock,
   input  wire line_req_type              line_req,
   output logic signed [SAMPLE_W-1:0]     line_rdata
);

   logic [SAMPLE_W-1:0] mem_ff [DELAY_DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (line_req.we) begin
         mem_ff[line_req.waddr] <= line_req.wdata;
      end
      rdata_ff <= mem_ff[line_req.raddr];
   end

   assign line_rdata = $signed(rdata_ff);

endmodule

`default_nettype wire

@@ rtl/sfda_csr.sv @@
// configuration registers behind the apb-style port
`default_nettype none

module sfda_csr
   import sfda_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   csr_index_type      idx;
   logic               wr;
   logic               wr_ok;
   logic               right_sel_ff;
   logic               right_sel_in;
   logic [WHOLE_W-1:0] whole_ff;
   logic [WHOLE_W-1:0] whole_in;
   logic [FRAC_W-1:0]  fraction_ff;
   logic [FRAC_W-1:0]  fraction_in;
   logic [WHOLE_W-1:0] whole_wr;

   assign idx        = csr_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign whole_wr   = (csr_pwdata[WHOLE_W-1:0] > WHOLE_MAX) ? WHOLE_MAX
                                                             : csr_pwdata[WHOLE_W-1:0];

   always_comb begin
      right_sel_in   = right_sel_ff;
      whole_in       = whole_ff;
      fraction_in    = fraction_ff;
      wr_ok          = 1'b0;
      csr_prdata     = '0;
      unique case (idx)
         CSR_RIGHT_SEL: begin
            csr_prdata = CSR_DW'(right_sel_ff);
            if (wr) begin
               right_sel_in = csr_pwdata[0];
               wr_ok        = 1'b1;
            end
         end
         CSR_WHOLE: begin
            csr_prdata = CSR_DW'(whole_ff);
            if (wr) begin
               whole_in = whole_wr;
               wr_ok    = 1'b1;
            end
         end
         CSR_FRACTION: begin
            csr_prdata = CSR_DW'(fraction_ff);
            if (wr) begin
               fraction_in = csr_pwdata[FRAC_W-1:0];
               wr_ok       = 1'b1;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_sel_ff   <= 1'b0;
         whole_ff       <= '0;
         fraction_ff    <= '0;
      end else begin
         right_sel_ff   <= right_sel_in;
         whole_ff       <= whole_in;
         fraction_ff    <= fraction_in;
      end
   end

   assign cfg.clear       = wr_ok;
   assign cfg.right_sel   = right_sel_ff;
   assign cfg.whole       = whole_ff;
   assign cfg.fraction    = fraction_ff;

endmodule

`default_nettype wire

@@ rtl/sfda_seq.sv @@
// sequencer: tap weight computation, five-tap multiply-accumulate and output register
`default_nettype none

module sfda_seq
   import sfda_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cfg_type                     cfg,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [SAMPLE_W-1:0]  req_left_in,
   input  wire logic signed [SAMPLE_W-1:0]  req_right_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]       rsp_left_out,
   output logic signed [SAMPLE_W-1:0]       rsp_right_out,
   output logic signed [MUL_W-1:0]          mul_a,
   output logic signed [MUL_W-1:0]          mul_b,
   input  wire logic signed [PROD_W-1:0]    mul_prod,
   output line_req_type                     line_req,
   input  wire logic signed [SAMPLE_W-1:0]  line_rdata
);

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_W - 1)));

   state_type                   state_ff, state_in;
   logic [TAP_W-1:0]            wt_ff, wt_in;
   logic signed [P_W-1:0]       p_ff, p_in;
   logic signed [P_W-1:0]       q_ff, q_in;
   logic signed [S_W-1:0]       s_ff, s_in;
   logic signed [W_W-1:0]       w_ff [NUM_TAPS];
   logic signed [W_W-1:0]       w_in [NUM_TAPS];
   logic [ADDR_W-1:0]           wp_ff, wp_in;
   logic [ADDR_W-1:0]           base_ff, base_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic signed [SAMPLE_W-1:0]  left_ff, left_in;
   logic signed [SAMPLE_W-1:0]  right_ff, right_in;
   logic                        byp_ff, byp_in;
   logic [TAP_W-1:0]            rd_cnt_ff, rd_cnt_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [TAP_W-1:0]            rd_tap_ff, rd_tap_in;
   logic                        rd_ok_ff, rd_ok_in;
   logic                        mac_vld_ff, mac_vld_in;
   logic                        mac_last_ff, mac_last_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0]  rsp_right_ff, rsp_right_in;

   logic [FILL_W-1:0]           back;
   logic signed [PROD_W-1:0]    s_full;
   logic signed [S_W-1:0]       s_sh;
   logic signed [ACC_W-1:0]     y_full;
   logic signed [SAMPLE_W-1:0]  y_sat;

   always_comb begin
      back   = FILL_W'(cfg.whole) + FILL_W'(rd_cnt_ff);
      s_full = tap_neg(wt_ff) ? (tap_half_den(wt_ff) - mul_prod)
                              : (mul_prod + tap_half_den(wt_ff));
      s_sh   = (tap_den(wt_ff) == DEN_24) ? (s_ff >>> 3) : (s_ff >>> 1);
      y_full = (acc_ff + ACC_W'(HALF_Q16)) >>> FRAC_W;
      if (y_full > SAT_HI) begin
         y_sat = SAMPLE_W'(SAT_HI);
      end else if (y_full < SAT_LO) begin
         y_sat = SAMPLE_W'(SAT_LO);
      end else begin
         y_sat = SAMPLE_W'(y_full);
      end
   end

   always_comb begin
      state_in     = state_ff;
      wt_in        = wt_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      s_in         = s_ff;
      w_in         = w_ff;
      wp_in        = wp_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      byp_in       = byp_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_tap_in    = rd_tap_ff;
      rd_ok_in     = rd_ok_ff;
      mac_vld_in   = 1'b0;
      mac_last_in  = 1'b0;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      req_stall    = 1'b1;
      mul_a        = '0;
      mul_b        = '0;
      line_req     = '0;

      unique case (state_ff)
         ST_W_AB: begin
            mul_a    = MUL_W'(node_dist(cfg.fraction, tap_node(wt_ff, 2'd0)));
            mul_b    = MUL_W'(node_dist(cfg.fraction, tap_node(wt_ff, 2'd1)));
            state_in = ST_W_CE;
         end
         ST_W_CE: begin
            p_in     = round_q16(mul_prod);
            mul_a    = MUL_W'(node_dist(cfg.fraction, tap_node(wt_ff, 2'd2)));
            mul_b    = MUL_W'(node_dist(cfg.fraction, tap_node(wt_ff, 2'd3)));
            state_in = ST_W_Q;
         end
         ST_W_Q: begin
            q_in     = round_q16(mul_prod);
            state_in = ST_W_PQ;
         end
         ST_W_PQ: begin
            mul_a    = MUL_W'(p_ff);
            mul_b    = MUL_W'(q_ff);
            state_in = ST_W_S;
         end
         ST_W_S: begin
            s_in     = S_W'(s_full >>> FRAC_W);
            state_in = ST_W_DIV;
         end
         ST_W_DIV: begin
            if (tap_den(wt_ff) == DEN_4) begin
               w_in[wt_ff] = W_W'(s_ff >>> 2);
               if (wt_ff == TAP_W'(NUM_TAPS - 1)) begin
                  wt_in    = '0;
                  state_in = ST_IDLE;
               end else begin
                  wt_in    = wt_ff + TAP_W'(1);
                  state_in = ST_W_AB;
               end
            end else begin
               // floor division by three through a reciprocal, offset keeps it positive
               mul_a    = MUL_W'(s_sh) + DIV3_OFS;
               mul_b    = DIV3_R;
               state_in = ST_W_FIN;
            end
         end
         ST_W_FIN: begin
            w_in[wt_ff] = W_W'((mul_prod >>> DIV3_K) - PROD_W'(2 ** DIV3_OFS_LOG));
            if (wt_ff == TAP_W'(NUM_TAPS - 1)) begin
               wt_in    = '0;
               state_in = ST_IDLE;
            end else begin
               wt_in    = wt_ff + TAP_W'(1);
               state_in = ST_W_AB;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               left_in   = req_left_in;
               right_in  = req_right_in;
               acc_in    = '0;
               rd_cnt_in = '0;
               if ((cfg.whole == '0) && (cfg.fraction == '0)) begin
                  byp_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  byp_in         = 1'b0;
                  line_req.we    = 1'b1;
                  line_req.waddr = wp_ff;
                  line_req.wdata = cfg.right_sel ? req_right_in : req_left_in;
                  base_in        = wp_ff;
                  wp_in          = wp_ff + ADDR_W'(1);
                  if (fill_ff != FILL_W'(DELAY_DEPTH)) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (rd_cnt_ff != TAP_W'(NUM_TAPS)) begin
               line_req.raddr = base_ff - back[ADDR_W-1:0];
               rd_vld_in      = 1'b1;
               rd_tap_in      = rd_cnt_ff;
               rd_ok_in       = back < fill_ff;
               rd_cnt_in      = rd_cnt_ff + TAP_W'(1);
            end
            if (rd_vld_ff) begin
               mul_a       = MUL_W'(w_ff[rd_tap_ff]);
               mul_b       = rd_ok_ff ? MUL_W'(line_rdata) : '0;
               mac_vld_in  = 1'b1;
               mac_last_in = rd_tap_ff == TAP_W'(NUM_TAPS - 1);
            end
            if (mac_vld_ff) begin
               acc_in = acc_ff + ACC_W'(mul_prod);
               if (mac_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (byp_ff) begin
                  rsp_left_in  = left_ff;
                  rsp_right_in = right_ff;
               end else if (cfg.right_sel) begin
                  rsp_left_in  = left_ff;
                  rsp_right_in = y_sat;
               end else begin
                  rsp_left_in  = y_sat;
                  rsp_right_in = right_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_W_AB;
            wt_in    = '0;
         end
      endcase

      // a write to any of the three configuration registers clears the line and recomputes the weights
      if (cfg.clear) begin
         state_in   = ST_W_AB;
         wt_in      = '0;
         wp_in      = '0;
         fill_in    = '0;
         rd_vld_in  = 1'b0;
         mac_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_W_AB;
         wt_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rd_cnt_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         mac_vld_ff   <= 1'b0;
         mac_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wt_ff        <= wt_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         mac_vld_ff   <= mac_vld_in;
         mac_last_ff  <= mac_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      q_ff         <= q_in;
      s_ff         <= s_in;
      w_ff         <= w_in;
      base_ff      <= base_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      byp_ff       <= byp_in;
      rd_tap_ff    <= rd_tap_in;
      rd_ok_ff     <= rd_ok_in;
      acc_ff       <= acc_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

`default_nettype wire

@@ rtl/stereo_fractional_delay_align_core.sv @@
// top level of the stereo fractional delay aligner
`default_nettype none

// Delays one channel of each stereo frame by a whole plus fractional sample count through a
// 2048-entry line and a five-tap Lagrange interpolator; the other channel passes unchanged.
// A delayed frame occupies the block for five reads of the single line read port feeding one
// shared multiplier, then rounding and saturation; req_stall stays high until its result is
// in the output register, so no new frame is accepted before then. A zero-delay frame skips
// the line. The tap weights are computed on the same multiplier after reset and after every
// write to a configuration register, which holds req_stall high. Such a write also empties
// the line; a fill count makes unwritten taps read zero, so there is no clearing pass. A
// finished result waits in the output register while the next request is accepted.

module stereo_fractional_delay_align_core
   import sfda_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [SAMPLE_W-1:0]  req_left_in,
   input  wire logic signed [SAMPLE_W-1:0]  req_right_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]       rsp_left_out,
   output logic signed [SAMPLE_W-1:0]       rsp_right_out,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [CSR_AW-1:0]           csr_paddr,
   input  wire logic [CSR_DW-1:0]           csr_pwdata,
   output logic [CSR_DW-1:0]                csr_prdata,
   output logic                             csr_pready
);

   cfg_type                   cfg;
   line_req_type              line_req;
   logic signed [SAMPLE_W-1:0] line_rdata;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]  mul_prod;

   sfda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfda_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   sfda_line u_line (
      .clock      (clock),
      .line_req   (line_req),
      .line_rdata (line_rdata)
   );

   sfda_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .mul_a         (mul_a),
      .mul_b         (mul_b),
      .mul_prod      (mul_prod),
      .line_req      (line_req),
      .line_rdata    (line_rdata)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous frame still in progress");

   a_busy_after_cfg: assert property (@(posedge clock) disable iff (reset)
      cfg.clear |=> req_stall)
      else $error("weights not recomputed after register write");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted before weights computed after reset");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench of the stereo fractional delay aligner core
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sfda_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      int                         gap;
   } frame_request_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_frame_type;

   localparam int CSR_SPARE      = 3;
   localparam int RANDOM_FRAMES  = 1650;
   localparam int DRAIN_CYCLES   = 12;
   localparam int END_CYCLES     = 20;
   localparam int LONG_HOLD      = 500;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic signed [SAMPLE_W-1:0] PEAK_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_left_in = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]          csr_paddr = '0;
   logic [CSR_DW-1:0]          csr_pwdata = '0;
   logic [CSR_DW-1:0]          csr_prdata;
   logic                       csr_pready;

   stereo_fractional_delay_align_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // aligner state mirror
   logic                       cfg_right = 1'b0;
   logic [WHOLE_W-1:0]         cfg_whole = '0;
   logic [FRAC_W-1:0]          cfg_fraction = '0;
   logic signed [SAMPLE_W-1:0] line_copy [DELAY_DEPTH];
   logic [ADDR_W-1:0]          line_wp = '0;
   longint                     tap_weight_q16 [NUM_TAPS];

   frame_request_type pending_frames [$];
   stereo_frame_type  expected_frames [$];

   int error_count = 0;
   int rsp_idle_max = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int stall_left = 0;
   int req_waited = 0;
   int idle_cycles = 0;
   logic req_offer;
   frame_request_type req_next;
   stereo_frame_type  rsp_want;

   function automatic longint round_half_up16(input longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0)
         q--;
      return q;
   endfunction

   function automatic longint lagrange_den(input int k);
      longint d;
      case (k)
         0, 4:    d = 24;
         1, 3:    d = -6;
         default: d = 4;
      endcase
      return d;
   endfunction

   function automatic void load_weights();
      longint node_gap [4];
      longint p, q, prod, den;
      int n, k, m;
      for (k = 0; k < NUM_TAPS; k++) begin
         n = 0;
         for (m = 0; m < NUM_TAPS; m++) begin
            if (m != k) begin
               node_gap[n] = longint'(cfg_fraction) - longint'(m) * 65536;
               n++;
            end
         end
         p = round_half_up16(node_gap[0] * node_gap[1]);
         q = round_half_up16(node_gap[2] * node_gap[3]);
         prod = p * q;
         den = lagrange_den(k);
         if (den < 0) begin
            prod = -prod;
            den = -den;
         end
         tap_weight_q16[k] = floor_div(2 * prod + den * 65536, 2 * den * 65536);
      end
   endfunction

   function automatic void clear_line();
      int i;
      for (i = 0; i < DELAY_DEPTH; i++)
         line_copy[i] = '0;
      line_wp = '0;
   endfunction

   function automatic stereo_frame_type align_frame(input logic signed [SAMPLE_W-1:0] left,
                                                    input logic signed [SAMPLE_W-1:0] right);
      stereo_frame_type res;
      longint acc, y;
      logic [ADDR_W-1:0] idx;
      int k;
      res.left = left;
      res.right = right;
      if (cfg_whole == '0 && cfg_fraction == '0)
         return res;
      line_copy[line_wp] = cfg_right ? right : left;
      acc = 0;
      for (k = 0; k < NUM_TAPS; k++) begin
         idx = ADDR_W'(line_wp - cfg_whole - k);
         acc += tap_weight_q16[k] * longint'(line_copy[idx]);
      end
      line_wp = line_wp + 1'b1;
      y = round_half_up16(acc);
      if (y > SAT_HI)
         y = SAT_HI;
      if (y < SAT_LO)
         y = SAT_LO;
      if (cfg_right)
         res.right = SAMPLE_W'(y);
      else
         res.left = SAMPLE_W'(y);
      return res;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 7))
         0:       s = PEAK_POS;
         1:       s = PEAK_NEG;
         2:       s = SAMPLE_W'(int'($urandom_range(0, 1024)) - 512);
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   // random upper bits that the register must ignore
   function automatic logic [CSR_DW-1:0] with_noise(input logic [CSR_DW-1:0] value,
                                                    input int width);
      if ($urandom_range(0, 1) == 0)
         return value;
      return value | ($urandom << width);
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_waited = 0;
      end else begin
         req_offer = req_valid;
         if (req_valid && !req_stall) begin
            expected_frames.push_back(align_frame(req_left_in, req_right_in));
            req_offer = 1'b0;
         end
         if (!req_offer && pending_frames.size() != 0) begin
            if (req_waited >= pending_frames[0].gap) begin
               req_next = pending_frames.pop_front();
               req_left_in <= req_next.left;
               req_right_in <= req_next.right;
               req_offer = 1'b1;
               req_waited = 0;
            end else begin
               req_waited++;
            end
         end
         req_valid <= req_offer;
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: result with nothing expected, left %0d right %0d",
                        $time, rsp_left_out, rsp_right_out);
               error_count++;
            end else begin
               rsp_want = expected_frames.pop_front();
               if (rsp_left_out !== rsp_want.left) begin
                  $display("%0t: left_out expected %0d actual %0d",
                           $time, rsp_want.left, rsp_left_out);
                  error_count++;
               end
               if (rsp_right_out !== rsp_want.right) begin
                  $display("%0t: right_out expected %0d actual %0d",
                           $time, rsp_want.right, rsp_right_out);
                  error_count++;
               end
            end
            stall_left = $urandom_range(0, rsp_idle_max);
         end
         if (holds_done != hold_requests) begin
            holds_done++;
            stall_left = LONG_HOLD;
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic csr_write(input int index, input logic [CSR_DW-1:0] data);
      logic [WHOLE_W-1:0] whole;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(index * 4);
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         CSR_RIGHT_SEL: cfg_right = data[0];
         CSR_WHOLE: begin
            whole = data[WHOLE_W-1:0];
            cfg_whole = (whole > WHOLE_MAX) ? WHOLE_MAX : whole;
         end
         CSR_FRACTION: cfg_fraction = data[FRAC_W-1:0];
         default: ;
      endcase
      if (index >= 0 && index <= int'(CSR_FRACTION)) begin
         clear_line();
         load_weights();
      end
   endtask

   task automatic set_delay(input logic right, input logic [CSR_DW-1:0] whole,
                            input logic [CSR_DW-1:0] frac);
      csr_write(CSR_RIGHT_SEL, CSR_DW'(right));
      csr_write(CSR_WHOLE, whole);
      csr_write(CSR_FRACTION, frac);
   endtask

   task automatic queue_frame(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right, input int gap);
      frame_request_type f;
      f.left = left;
      f.right = right;
      f.gap = gap;
      pending_frames.push_back(f);
   endtask

   task automatic queue_random(input int count, input int idle_max);
      int i;
      for (i = 0; i < count; i++)
         queue_frame(draw_sample(), draw_sample(), $urandom_range(0, idle_max));
   endtask

   task automatic wait_drained();
      while (pending_frames.size() != 0 || expected_frames.size() != 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int i, phase, random_sent, count, idle_max, pick;
      logic right;
      logic [WHOLE_W-1:0] whole;
      logic [FRAC_W-1:0] frac;
      clear_line();
      load_weights();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings give a bypass
      rsp_idle_max = 2;
      queue_frame(PEAK_POS, PEAK_NEG, 0);
      queue_frame(PEAK_NEG, PEAK_POS, 1);
      queue_frame('0, '0, 0);
      queue_frame(SAMPLE_W'(-1), SAMPLE_W'(1), 2);
      wait_drained();

      // half-sample delay on left, alternating full scale overshoots
      set_delay(1'b0, 0, 32'h8000);
      for (i = 0; i < 6; i++)
         queue_frame((i % 2) ? PEAK_NEG : PEAK_POS, draw_sample(), 0);
      wait_drained();

      // spare register write keeps the line
      csr_write(CSR_SPARE, $urandom);
      for (i = 0; i < 4; i++)
         queue_frame((i % 2) ? PEAK_POS : PEAK_NEG, draw_sample(), 1);
      wait_drained();

      // oversized whole delay clamps, history still empty
      set_delay(1'b1, 2047, 32'hFFFF);
      for (i = 0; i < 3; i++)
         queue_frame(draw_sample(), PEAK_POS, 0);
      wait_drained();

      // integer delay on right
      set_delay(1'b1, 2, 0);
      queue_frame(SAMPLE_W'(1), PEAK_POS, 0);
      queue_frame(SAMPLE_W'(2), PEAK_NEG, 0);
      queue_frame(SAMPLE_W'(3), SAMPLE_W'(1), 3);
      queue_frame(SAMPLE_W'(4), SAMPLE_W'(-1), 0);
      queue_frame(SAMPLE_W'(5), PEAK_POS, 0);
      queue_frame(SAMPLE_W'(6), '0, 0);
      wait_drained();

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_FRAMES) begin
         right = 1'($urandom_range(0, 1));
         frac = FRAC_W'($urandom);
         count = 120;
         case (phase)
            0: begin
               whole = '0;
               frac = 16'hFFFF;
            end
            1: whole = WHOLE_W'($urandom_range(1, 8));
            2: begin
               whole = WHOLE_W'($urandom_range(100, 150));
               count = 250;
            end
            3: begin
               whole = WHOLE_W'($urandom_range(2040, 2047));
               count = 30;
            end
            4: begin
               whole = WHOLE_W'($urandom_range(1, 4));
               frac = FRAC_W'(1);
            end
            default: begin
               pick = $urandom_range(0, 9);
               if (pick < 2)
                  whole = '0;
               else if (pick < 6)
                  whole = WHOLE_W'($urandom_range(1, 8));
               else if (pick < 8)
                  whole = WHOLE_W'($urandom_range(9, 64));
               else
                  whole = WHOLE_W'($urandom);
               pick = $urandom_range(0, 9);
               if (pick < 2)
                  frac = '0;
               else if (pick < 3)
                  frac = 16'hFFFF;
               else if (pick < 4)
                  frac = FRAC_W'(1);
               if (whole > 64)
                  count = 40;
            end
         endcase
         idle_max = (phase % 4 == 3) ? 0 : 6;
         rsp_idle_max = idle_max;
         if (phase % 5 == 4)
            csr_write(CSR_SPARE, $urandom);
         set_delay(right, with_noise(CSR_DW'(whole), WHOLE_W),
                   with_noise(CSR_DW'(frac), FRAC_W));
         queue_random(count, idle_max);
         if (phase == 1)
            hold_requests++;
         random_sent += count;
         phase++;
         wait_drained();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
